FILE: hw/rtl/ivol_pkg.sv
// Shared types, register codes and helpers for the integral-volume block.
// No dependencies; every other file imports this package.
package ivol_pkg;

   localparam int SIZE_BITS     = 13;  // holds any effective size, up to 4096
   localparam int Z_BITS        = 12;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 13;
   localparam int VOXEL_BITS    = 32;
   localparam int OUT_BITS      = 32;
   localparam int OUTQ_DEPTH    = 3;
   localparam int OUTQ_PTR_BITS = 2;
   localparam int DEPTH_LIMIT   = 4096;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_DEPTH  = 2'd2
   } reg_index_type;

   // Per-request control carried from the scan stage into the accumulator.
   typedef struct packed {
      logic valid;
      logic add_line;   // row index is nonzero
      logic add_slice;  // slice index is nonzero
      logic last;       // final voxel of the volume
   } issue_ctrl_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] integral_value;
      logic                last_of_volume;
   } result_type;

   // Zero reads as one, anything over the limit as the limit.
   function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] value,
                                                       input logic [SIZE_BITS-1:0] limit);
      logic [SIZE_BITS-1:0] res;
      if (value == '0) begin
         res = SIZE_BITS'(1);
      end else if (value > limit) begin
         res = limit;
      end else begin
         res = value;
      end
      return res;
   endfunction

endpackage

FILE: hw/rtl/ivol_req_if.sv
// Request channel: one voxel per request.
// Depends on ivol_pkg for the field width.
interface ivol_req_if import ivol_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [VOXEL_BITS-1:0] voxel_value;

   modport source (output valid, output voxel_value, input ready);
   modport sink (input valid, input voxel_value, output ready);
endinterface

FILE: hw/rtl/ivol_rsp_if.sv
// Result channel: integral value and end-of-volume flag.
// Depends on ivol_pkg for the field width.
interface ivol_rsp_if import ivol_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OUT_BITS-1:0] integral_value;
   logic                last_of_volume;

   modport source (output valid, output integral_value, output last_of_volume, input ready);
   modport sink (input valid, input integral_value, input last_of_volume, output ready);
endinterface

FILE: hw/rtl/ivol_csr_if.sv
// Configuration write channel: register index and write data.
// Depends on ivol_pkg for the field widths.
interface ivol_csr_if import ivol_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_BITS-1:0]  index;
   logic [CSR_DATA_BITS-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/integral_volume_3d.sv
// Streaming 3D summed-volume table.
// Voxels enter on req_if in raster order (x fastest, then y, then z); each request
// returns one result on rsp_if: the wrapped sum of all voxels at or below its x, y
// and z, plus a flag on the final voxel of the volume. Sizes are set on csr_if
// (index 0 width, 1 height, 2 depth; width and height use data bits 8:0 only; zero
// reads as one, oversize as the maximum); the user must set them only while no
// request is outstanding, which the block itself does not enforce. csr_if is always
// ready. Throughput is one request per cycle while the output queue has room. Each
// request does one read-modify-write of the line store and one of the slice store;
// the slice store holds 2**(XW+YW) entries, each read on accept and written in the
// next cycle, with the in-flight write forwarded when the next request hits it. A
// result passes the accumulator register and the queue before rsp_if.valid rises.
// A 3-entry output queue absorbs a stalled receiver; req_if.ready drops only when
// queued plus in-flight results would overflow it, so with rsp_if.ready held high
// requests flow every cycle. The stores hold garbage after reset and need no
// clearing: each entry is written in the first slice or row before it is read.
// Reset returns the size registers to width 256, height 256, depth 1 (width and
// height clamped to the maxima) and the scan to the start of a volume.
// req_if.ready is low while reset is asserted.
module integral_volume_3d import ivol_pkg::*; #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int SUM_BITS   = 32
) (
   input  logic         clock,
   input  logic         reset,
   ivol_req_if.sink     req_if,
   ivol_rsp_if.source   rsp_if,
   ivol_csr_if.sink     csr_if
);

   localparam int XW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
   localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   logic                     accept;
   logic [XW-1:0]            line_addr;
   logic [XW+YW-1:0]         slice_addr;
   logic [SUM_BITS-1:0]      row_sum;
   issue_ctrl_type           ctrl;
   logic                     acc_valid;
   result_type               acc_result;
   logic                     head_valid;
   result_type               head_data;
   logic [OUTQ_PTR_BITS-1:0] q_count;
   logic [OUTQ_PTR_BITS:0]   pending;

   assign pending       = (OUTQ_PTR_BITS+1)'(q_count) + (OUTQ_PTR_BITS+1)'(acc_valid);
   assign req_if.ready  = !reset && (pending < (OUTQ_PTR_BITS+1)'(OUTQ_DEPTH));
   assign accept        = req_if.valid && req_if.ready;
   assign csr_if.ready  = 1'b1;

   assign rsp_if.valid          = head_valid;
   assign rsp_if.integral_value = head_data.integral_value;
   assign rsp_if.last_of_volume = head_data.last_of_volume;

   ivol_scan #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .SUM_BITS   (SUM_BITS),
      .XW         (XW),
      .YW         (YW)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .voxel_value (req_if.voxel_value),
      .csr_write   (csr_if.valid && csr_if.ready),
      .csr_index   (csr_if.index),
      .csr_data    (csr_if.data),
      .line_addr   (line_addr),
      .slice_addr  (slice_addr),
      .row_sum     (row_sum),
      .ctrl        (ctrl)
   );

   ivol_accum #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .SUM_BITS   (SUM_BITS),
      .XW         (XW),
      .YW         (YW)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .line_addr  (line_addr),
      .slice_addr (slice_addr),
      .row_sum    (row_sum),
      .ctrl       (ctrl),
      .out_valid  (acc_valid),
      .out_result (acc_result)
   );

   ivol_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (acc_valid),
      .push_data  (acc_result),
      .pop        (rsp_if.ready),
      .head_valid (head_valid),
      .head_data  (head_data),
      .count      (q_count)
   );

   assert property (@(posedge clock) disable iff (reset)
      accept |=> acc_valid)
      else $error("accepted request did not reach accumulator");

   assert property (@(posedge clock) disable iff (reset)
      !accept |=> !acc_valid)
      else $error("accumulator produced a result with no request");

   assert property (@(posedge clock) disable iff (reset)
      pending <= (OUTQ_PTR_BITS+1)'(OUTQ_DEPTH))
      else $error("more results in flight than the queue holds");

endmodule

FILE: hw/rtl/ivol_scan.sv
// Raster scan stage: size registers, x/y/z position counters, row running sum,
// and the store addresses for each accepted request. Depends on ivol_pkg.
module ivol_scan import ivol_pkg::*; #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int SUM_BITS   = 32,
   parameter int XW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1,
   parameter int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [VOXEL_BITS-1:0]    voxel_value,
   input  logic                     csr_write,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data,
   output logic [XW-1:0]            line_addr,
   output logic [XW+YW-1:0]         slice_addr,
   output logic [SUM_BITS-1:0]      row_sum,
   output issue_ctrl_type           ctrl
);

   localparam int IN_BITS = (SUM_BITS < VOXEL_BITS) ? SUM_BITS : VOXEL_BITS;
   localparam logic [SIZE_BITS-1:0] WIDTH_LIMIT  = SIZE_BITS'(MAX_WIDTH);
   localparam logic [SIZE_BITS-1:0] HEIGHT_LIMIT = SIZE_BITS'(MAX_HEIGHT);
   localparam logic [SIZE_BITS-1:0] DEPTH_MAX    = SIZE_BITS'(DEPTH_LIMIT);

   logic [SIZE_BITS-1:0] width_ff, width_in;
   logic [SIZE_BITS-1:0] height_ff, height_in;
   logic [SIZE_BITS-1:0] depth_ff, depth_in;
   logic [XW-1:0]        x_ff, x_in;
   logic [YW-1:0]        y_ff, y_in;
   logic [Z_BITS-1:0]    z_ff, z_in;
   logic [SUM_BITS-1:0]  row_ff, row_in;
   logic [SUM_BITS-1:0]  voxel;
   logic                 end_row, end_slice, end_vol;

   assign voxel  = SUM_BITS'(voxel_value[IN_BITS-1:0]);
   assign row_in = (x_ff == '0) ? voxel : row_ff + voxel;

   assign end_row   = (SIZE_BITS'(x_ff) + SIZE_BITS'(1)) >= width_ff;
   assign end_slice = end_row && ((SIZE_BITS'(y_ff) + SIZE_BITS'(1)) >= height_ff);
   assign end_vol   = end_slice && ((SIZE_BITS'(z_ff) + SIZE_BITS'(1)) >= depth_ff);

   assign line_addr      = x_ff;
   assign slice_addr     = {y_ff, x_ff};
   assign row_sum        = row_in;
   assign ctrl.valid     = accept;
   assign ctrl.add_line  = (y_ff != '0);
   assign ctrl.add_slice = (z_ff != '0);
   assign ctrl.last      = end_vol;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      depth_in  = depth_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_WIDTH:  width_in  = clamp_size(SIZE_BITS'(csr_data[8:0]), WIDTH_LIMIT);
            REG_HEIGHT: height_in = clamp_size(SIZE_BITS'(csr_data[8:0]), HEIGHT_LIMIT);
            REG_DEPTH:  depth_in  = clamp_size(csr_data, DEPTH_MAX);
            default: ;
         endcase
      end
   end

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (accept) begin
         if (!end_row) begin
            x_in = x_ff + XW'(1);
         end else begin
            x_in = '0;
            if (!end_slice) begin
               y_in = y_ff + YW'(1);
            end else begin
               y_in = '0;
               z_in = end_vol ? '0 : z_ff + Z_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= clamp_size(SIZE_BITS'(256), WIDTH_LIMIT);
         height_ff <= clamp_size(SIZE_BITS'(256), HEIGHT_LIMIT);
         depth_ff  <= SIZE_BITS'(1);
         x_ff      <= '0;
         y_ff      <= '0;
         z_ff      <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         depth_ff  <= depth_in;
         x_ff      <= x_in;
         y_ff      <= y_in;
         z_ff      <= z_in;
         if (accept) begin
            row_ff <= row_in;
         end
      end
   end

endmodule

FILE: hw/rtl/ivol_accum.sv
// Line store and slice store with read-modify-write and same-address forwarding.
// Reads issue on accept; sums and write-back happen in the following cycle. Depends on ivol_pkg.
module ivol_accum import ivol_pkg::*; #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int SUM_BITS   = 32,
   parameter int XW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1,
   parameter int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [XW-1:0]       line_addr,
   input  logic [XW+YW-1:0]    slice_addr,
   input  logic [SUM_BITS-1:0] row_sum,
   input  issue_ctrl_type      ctrl,
   output logic                out_valid,
   output result_type          out_result
);

   localparam int SLICE_ENTRIES = 2 ** (XW + YW);
   localparam int OB = (SUM_BITS < OUT_BITS) ? SUM_BITS : OUT_BITS;

   logic [SUM_BITS-1:0] line_mem  [MAX_WIDTH];
   logic [SUM_BITS-1:0] slice_mem [SLICE_ENTRIES];

   logic                s1_valid_ff;
   issue_ctrl_type      s1_ctrl_ff;
   logic [XW-1:0]       s1_line_addr_ff;
   logic [XW+YW-1:0]    s1_slice_addr_ff;
   logic [SUM_BITS-1:0] s1_row_ff;
   logic [SUM_BITS-1:0] line_rd_ff, slice_rd_ff;
   logic                line_hit_ff, line_hit_in;
   logic                slice_hit_ff, slice_hit_in;
   logic [SUM_BITS-1:0] line_fwd_ff, slice_fwd_ff;
   logic [SUM_BITS-1:0] line_val, slice_val, plane, total;

   // The write of the request in flight lands on the same edge as the next read.
   assign line_hit_in  = s1_valid_ff && (s1_line_addr_ff == line_addr);
   assign slice_hit_in = s1_valid_ff && (s1_slice_addr_ff == slice_addr);

   assign line_val  = line_hit_ff ? line_fwd_ff : line_rd_ff;
   assign slice_val = slice_hit_ff ? slice_fwd_ff : slice_rd_ff;

   assign plane = s1_row_ff + (s1_ctrl_ff.add_line ? line_val : '0);
   assign total = plane + (s1_ctrl_ff.add_slice ? slice_val : '0);

   assign out_valid                 = s1_valid_ff;
   assign out_result.integral_value = OUT_BITS'(total[OB-1:0]);
   assign out_result.last_of_volume = s1_ctrl_ff.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.valid) begin
         s1_ctrl_ff       <= ctrl;
         s1_line_addr_ff  <= line_addr;
         s1_slice_addr_ff <= slice_addr;
         s1_row_ff        <= row_sum;
         line_hit_ff      <= line_hit_in;
         slice_hit_ff     <= slice_hit_in;
         line_fwd_ff      <= plane;
         slice_fwd_ff     <= total;
      end
   end

   always_ff @(posedge clock) begin
      line_rd_ff <= line_mem[line_addr];
      if (s1_valid_ff) begin
         line_mem[s1_line_addr_ff] <= plane;
      end
   end

   always_ff @(posedge clock) begin
      slice_rd_ff <= slice_mem[slice_addr];
      if (s1_valid_ff) begin
         slice_mem[s1_slice_addr_ff] <= total;
      end
   end

   // A forward hit must come from a write that was really in flight.
   assert property (@(posedge clock) disable iff (reset)
      ctrl.valid && line_hit_in |-> s1_valid_ff)
      else $error("line forward without pending write");

   // Same row in the slice means same column, so a slice hit implies a line hit.
   assert property (@(posedge clock) disable iff (reset)
      ctrl.valid && slice_hit_in |-> line_hit_in)
      else $error("slice forward without matching line forward");

   assert property (@(posedge clock) disable iff (reset)
      ctrl.valid |=> s1_valid_ff && (s1_line_addr_ff == $past(line_addr)))
      else $error("request lost between scan and accumulate");

endmodule

FILE: hw/rtl/ivol_outq.sv
// Small output queue that decouples the accumulator from result back-pressure.
// Depends on ivol_pkg for the result type and queue depth.
module ivol_outq import ivol_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  result_type               push_data,
   input  logic                     pop,
   output logic                     head_valid,
   output result_type               head_data,
   output logic [OUTQ_PTR_BITS-1:0] count
);

   result_type                 entry_ff [OUTQ_DEPTH];
   logic [OUTQ_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [OUTQ_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [OUTQ_PTR_BITS-1:0]   count_ff, count_in;
   logic                       do_pop;

   localparam logic [OUTQ_PTR_BITS-1:0] LAST_PTR = OUTQ_PTR_BITS'(OUTQ_DEPTH - 1);

   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign count      = count_ff;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + OUTQ_PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + OUTQ_PTR_BITS'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + OUTQ_PTR_BITS'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - OUTQ_PTR_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= OUTQ_PTR_BITS'(OUTQ_DEPTH))
      else $error("output queue count out of range");

   assert property (@(posedge clock) disable iff (reset)
      push && (count_ff == OUTQ_PTR_BITS'(OUTQ_DEPTH)) |-> do_pop)
      else $error("push into full output queue");

   assert property (@(posedge clock) disable iff (reset)
      push && !do_pop |=> count_ff == $past(count_ff) + OUTQ_PTR_BITS'(1))
      else $error("output queue count did not track push");

endmodule
